// ----- rtl/bsd_pkg.sv -----
// shared types and constants of the byte-stuffing deframer
package bsd_pkg;

    // upper bound on the payload limit, applied over the max_payload register
    localparam logic [8:0] PAYLOAD_CAP = 9'd256;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DELIM    = 3'd0;
    localparam logic [2:0] REG_ESCAPE   = 3'd1;
    localparam logic [2:0] REG_MASK     = 3'd2;
    localparam logic [2:0] REG_MAX_PAY  = 3'd3;
    localparam logic [2:0] REG_CAPACITY = 3'd4;

    // result queue between front and back
    localparam int unsigned QUEUE_AW = 2;

    // tdata width of the result channel: data, status, length, padded to bytes
    localparam int unsigned OUT_TDATA_W = 24;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] escape;
        logic [7:0] mask;
        logic [8:0] max_payload;
        logic [8:0] out_capacity;
    } t_cfg;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        logic [1:0] status;
        logic [8:0] length;
    } t_tok;

endpackage

// ----- rtl/bsd_front.sv -----
// front end: frame tracking, unescaping and result generation per input byte
module bsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output bsd_pkg::t_tok o_tok
);
    import bsd_pkg::*;

    // byte position codes
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_BODY   = 2'd2;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic       r_esc;
    logic       n_esc;
    logic [1:0] r_err;
    logic [1:0] n_err;
    logic [8:0] r_cnt;
    logic [8:0] n_cnt;

    logic       acc;
    logic [8:0] limit;
    logic [7:0] unesc;
    logic       take;
    logic [7:0] take_val;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign limit   = (i_cfg.max_payload < PAYLOAD_CAP) ? i_cfg.max_payload : PAYLOAD_CAP;
    assign unesc   = i_byte ^ i_cfg.mask;

    // per-byte decision
    always_comb begin
        n_pos    = r_pos;
        n_esc    = r_esc;
        n_err    = r_err;
        n_cnt    = r_cnt;
        o_push   = 1'b0;
        o_tok    = '0;
        take     = 1'b0;
        take_val = i_byte;
        if (acc) begin
            if (i_last) begin
                // closing byte: one status transfer, then start over
                o_push          = 1'b1;
                o_tok.is_status = 1'b1;
                if (r_pos != POS_BODY || i_byte != i_cfg.delim) begin
                    o_tok.status = ST_INVALID;
                end else if (r_err != ST_OK) begin
                    o_tok.status = r_err;
                end else if (r_esc || r_cnt == 9'd0) begin
                    o_tok.status = ST_INVALID;
                end else begin
                    o_tok.status = ST_OK;
                    o_tok.length = r_cnt;
                end
                n_pos = POS_FIRST;
                n_esc = 1'b0;
                n_err = ST_OK;
                n_cnt = 9'd0;
            end else if (r_pos == POS_FIRST) begin
                if (i_byte != i_cfg.delim) begin
                    n_err = ST_INVALID;
                end
                n_pos = POS_SECOND;
            end else begin
                n_pos = POS_BODY;
                if (r_err == ST_OK) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (unesc != i_cfg.delim && unesc != i_cfg.escape) begin
                            n_err = ST_INVALID;
                        end else begin
                            take     = 1'b1;
                            take_val = unesc;
                        end
                    end else if (i_byte == i_cfg.delim) begin
                        n_err = ST_INVALID;
                    end else if (i_byte == i_cfg.escape) begin
                        n_esc = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
        end

        // decoded byte: limit first, then receiver capacity
        if (take) begin
            if (r_cnt >= limit) begin
                n_err = ST_INVALID;
            end else if (r_cnt >= i_cfg.out_capacity) begin
                n_err = ST_CAPACITY;
            end else begin
                n_cnt      = r_cnt + 9'd1;
                o_push     = 1'b1;
                o_tok.data = take_val;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
            r_esc <= 1'b0;
            r_err <= ST_OK;
            r_cnt <= 9'd0;
        end else begin
            r_pos <= n_pos;
            r_esc <= n_esc;
            r_err <= n_err;
            r_cnt <= n_cnt;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= PAYLOAD_CAP)
        else $error("decoded count above payload cap");

    a_esc_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_err == ST_OK))
        else $error("escape pending while an error is recorded");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> (r_pos == POS_FIRST && r_cnt == 9'd0 && !r_esc))
        else $error("frame state not cleared after closing byte");
`endif

endmodule

// ----- rtl/bsd_queue.sv -----
// small result queue decoupling the front end from the output stage
module bsd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsd_pkg::t_tok i_tok,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output bsd_pkg::t_tok o_tok
);
    import bsd_pkg::*;

    t_tok                r_mem [2**QUEUE_AW];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    // count never exceeds the depth, so the top bit alone marks full
    assign o_full  = r_count[QUEUE_AW];
    assign o_empty = (r_count == '0);
    assign o_tok   = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty result queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr - r_rptr) == r_count[QUEUE_AW-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- rtl/bsd_back.sv -----
// back end: output register that packs queued results onto the result channel
module bsd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  bsd_pkg::t_tok                     i_tok,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [bsd_pkg::OUT_TDATA_W-1:0]   o_tdata,
    output logic                              o_tuser
);
    import bsd_pkg::*;

    logic                   r_valid;
    logic                   n_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;
    logic                   r_tuser;

    // load whenever the register is free or its transfer completes
    assign o_pop   = !i_empty && (!r_valid || i_tready);
    assign n_valid = o_pop || (r_valid && !i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload packing: data, status, length from bit 0 up
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tdata <= {5'd0, i_tok.length, i_tok.status, i_tok.data};
            r_tuser <= i_tok.is_status;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_tready) |-> !o_pop)
        else $error("output register overwritten while stalled");

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped result not presented");

    a_data_zero_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tuser) |-> (r_tdata[7:0] == 8'd0))
        else $error("status transfer carries data byte");
`endif

endmodule

// ----- rtl/byte_stuffing_deframer.sv -----
// top level of the byte-stuffing deframer: register file, front, queue, back
//
// channel   dir  handshake           payload
// i_s_*     in   tvalid/tready       tdata[7:0] frame_byte, tlast frame_last
// o_m_*     out  tvalid/tready       tdata data_byte/status/length, tuser is_status
// apb       in   psel/penable/pwrite regs at 0x00..0x10, pready tied high
//
// one byte per cycle unless the queue is full; frame state updates at the accepting edge
// a result passes through the result queue and the output register to raise o_m_tvalid
// a four-entry result queue absorbs output stalls; input stalls only when it fills
// synchronous reset restores register defaults, clears frame state, queue and output valid
module byte_stuffing_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] frame_byte
    input  logic        i_s_tlast,
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] data_byte, [9:8] status, [18:10] decoded_len
    output logic        o_m_tuser,   // [0] is_status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bsd_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic       push;
    t_tok       push_tok;
    logic       full;
    logic       pop;
    logic       empty;
    t_tok       head_tok;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim        <= 8'd126;
            r_cfg.escape       <= 8'd125;
            r_cfg.mask         <= 8'd32;
            r_cfg.max_payload  <= 9'd256;
            r_cfg.out_capacity <= 9'd256;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DELIM:    r_cfg.delim        <= pwdata[7:0];
                REG_ESCAPE:   r_cfg.escape       <= pwdata[7:0];
                REG_MASK:     r_cfg.mask         <= pwdata[7:0];
                REG_MAX_PAY:  r_cfg.max_payload  <= pwdata[8:0];
                REG_CAPACITY: r_cfg.out_capacity <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_DELIM:    prdata = {24'd0, r_cfg.delim};
            REG_ESCAPE:   prdata = {24'd0, r_cfg.escape};
            REG_MASK:     prdata = {24'd0, r_cfg.mask};
            REG_MAX_PAY:  prdata = {23'd0, r_cfg.max_payload};
            REG_CAPACITY: prdata = {23'd0, r_cfg.out_capacity};
            default:      prdata = 32'd0;
        endcase
    end

    bsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_tok   (push_tok)
    );

    bsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_tok   (head_tok)
    );

    bsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_tok    (head_tok),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser)
    );

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the byte-stuffing deframer: stream driver, predictor, result checker
`timescale 1ns / 100ps

module testbench;
    import bsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PRINT_LIMIT  = 30;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_raw_byte;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // stream and register port drives
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'd0;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = 5'd0;
    logic [31:0] pwdata     = 32'd0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic [31:0] prdata;
    logic        pready;

    // register copy seen by the predictor
    t_cfg cfg = '{8'h7E, 8'h7D, 8'h20, 9'd256, 9'd256};

    // frame state of the predictor
    logic [1:0] frm_pos     = 2'd0;
    logic       frm_esc     = 1'b0;
    logic [1:0] frm_err     = ST_OK;
    logic [8:0] frm_decoded = 9'd0;

    t_raw_byte   byte_queue[$];
    t_tok        expected_results[$];
    logic [7:0]  frame_buf[$];

    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;
    logic        hold_kick     = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    int unsigned mismatches     = 0;
    int unsigned bytes_accepted = 0;
    int unsigned data_out       = 0;
    int unsigned frames_ok      = 0;
    int unsigned frames_invalid = 0;
    int unsigned frames_cap     = 0;

    byte_stuffing_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // deframer prediction: one raw byte in, at most one result out
    function automatic bit deframe_byte(input logic [7:0] b, input logic last,
                                        output t_tok res);
        logic [8:0] limit;
        logic [7:0] v;
        logic [1:0] st;
        res = '0;
        if (last) begin
            st = ST_OK;
            // framing errors win over interior ones
            if (frm_pos < 2'd2 || b != cfg.delim)
                st = ST_INVALID;
            else if (frm_err != ST_OK)
                st = frm_err;
            else if (frm_esc || frm_decoded == 9'd0)
                st = ST_INVALID;
            res.is_status = 1'b1;
            res.status    = st;
            res.length    = (st == ST_OK) ? frm_decoded : 9'd0;
            frm_pos     = 2'd0;
            frm_esc     = 1'b0;
            frm_err     = ST_OK;
            frm_decoded = 9'd0;
            return 1'b1;
        end
        if (frm_pos == 2'd0) begin
            if (b != cfg.delim)
                frm_err = ST_INVALID;
            frm_pos = 2'd1;
            return 1'b0;
        end
        frm_pos = 2'd2;
        if (frm_err != ST_OK)
            return 1'b0;
        if (frm_esc) begin
            // escaped byte must decode to delimiter or escape
            v = b ^ cfg.mask;
            frm_esc = 1'b0;
            if (v != cfg.delim && v != cfg.escape) begin
                frm_err = ST_INVALID;
                return 1'b0;
            end
        end else if (b == cfg.delim) begin
            frm_err = ST_INVALID;
            return 1'b0;
        end else if (b == cfg.escape) begin
            frm_esc = 1'b1;
            return 1'b0;
        end else begin
            v = b;
        end
        // payload limit first, then receiver room
        limit = (cfg.max_payload > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg.max_payload;
        if (frm_decoded >= limit) begin
            frm_err = ST_INVALID;
            return 1'b0;
        end
        if (frm_decoded >= cfg.out_capacity) begin
            frm_err = ST_CAPACITY;
            return 1'b0;
        end
        frm_decoded = frm_decoded + 9'd1;
        res.data = v;
        return 1'b1;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // input stream driver fed from the byte queue
    always @(posedge i_clk) begin : drive_bytes
        t_tok      res;
        t_raw_byte nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                if (deframe_byte(i_s_tdata, i_s_tlast, res))
                    expected_results.push_back(res);
                bytes_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = byte_queue.pop_front();
                    i_s_tdata  <= nxt.data;
                    i_s_tlast  <= nxt.last;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin : check_results
        t_tok want;
        t_tok got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.is_status = o_m_tuser;
                got.data      = o_m_tdata[7:0];
                got.status    = o_m_tdata[9:8];
                got.length    = o_m_tdata[18:10];
                if (got.is_status === 1'b0)
                    data_out++;
                else if (got.status == ST_OK)
                    frames_ok++;
                else if (got.status == ST_CAPACITY)
                    frames_cap++;
                else
                    frames_invalid++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display("%0t: unexpected transfer, expected none, got tuser %b tdata %h",
                                 $time, o_m_tuser, o_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= PRINT_LIMIT)
                            $display({"%0t: mismatch, expected is_status %0d data %h status %0d",
                                      " length %0d, got is_status %0d data %h status %0d",
                                      " length %0d"},
                                     $time, want.is_status, want.data, want.status,
                                     want.length, got.is_status, got.data, got.status,
                                     got.length);
                    end
                end
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= dst_stall_pct);
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        t_raw_byte it;
        it.data = b;
        it.last = last;
        byte_queue.push_back(it);
    endtask

    // well-formed frame with n stuffed payload bytes into frame_buf
    task automatic build_frame(input int n);
        logic [7:0] v;
        int         k;
        frame_buf.delete();
        frame_buf.push_back(cfg.delim);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       v = cfg.delim;
                1:       v = cfg.escape;
                default: v = 8'($urandom_range(255));
            endcase
            if (v == cfg.delim || v == cfg.escape) begin
                frame_buf.push_back(cfg.escape);
                frame_buf.push_back(v ^ cfg.mask);
            end else begin
                frame_buf.push_back(v);
            end
        end
        frame_buf.push_back(cfg.delim);
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_buf.size(); k++)
            add_byte(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    // mostly clean frames with random content, the rest broken on purpose
    task automatic add_random_frames(input int budget);
        int         queued;
        int         n;
        int         k;
        int         p;
        logic [8:0] lim;
        queued = 0;
        while (queued < budget) begin
            lim = (cfg.max_payload < cfg.out_capacity) ? cfg.max_payload : cfg.out_capacity;
            if ($urandom_range(9) == 0 && lim < 30)
                n = lim + $urandom_range(2);
            else
                n = $urandom_range(10);
            build_frame(n);
            if ($urandom_range(99) >= 80) begin
                p = $urandom_range(1, frame_buf.size() - 1);
                case ($urandom_range(5))
                    // bad opening byte
                    0: frame_buf[0] = 8'($urandom_range(255));
                    // bad closing byte
                    1: frame_buf[frame_buf.size() - 1] = 8'($urandom_range(255));
                    // stray delimiter inside
                    2: frame_buf.insert(p, cfg.delim);
                    // escape followed by an arbitrary byte
                    3: begin
                        frame_buf.insert(p, 8'($urandom_range(255)));
                        frame_buf.insert(p, cfg.escape);
                    end
                    // escape just before the closing byte
                    4: frame_buf.insert(frame_buf.size() - 1, cfg.escape);
                    // short or junk buffer
                    default: begin
                        frame_buf.delete();
                        n = $urandom_range(1, 6);
                        for (k = 0; k < n; k++)
                            frame_buf.push_back(($urandom_range(2) == 0) ? cfg.delim
                                                : 8'($urandom_range(255)));
                    end
                endcase
            end
            queued += frame_buf.size();
            send_frame();
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (byte_queue.size() != 0 || i_s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // register write: setup then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELIM:    cfg.delim        = val[7:0];
            REG_ESCAPE:   cfg.escape       = val[7:0];
            REG_MASK:     cfg.mask         = val[7:0];
            REG_MAX_PAY:  cfg.max_payload  = val;
            REG_CAPACITY: cfg.out_capacity = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] d, input logic [7:0] e, input logic [7:0] m,
                             input logic [8:0] mp, input logic [8:0] oc,
                             input int unsigned src, input int unsigned dst);
        wait_idle();
        write_reg(REG_DELIM, {1'b0, d});
        write_reg(REG_ESCAPE, {1'b0, e});
        write_reg(REG_MASK, {1'b0, m});
        write_reg(REG_MAX_PAY, mp);
        write_reg(REG_CAPACITY, oc);
        @(negedge i_clk);
        src_idle_pct  = src;
        dst_stall_pct = dst;
    endtask

    // reset, then stimulus phases
    initial begin : stimulus
        logic [7:0] d;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames under reset settings, no idling
        add_byte(cfg.delim, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0);
        add_byte(cfg.delim, 1'b1);
        add_byte(cfg.delim, 1'b0); add_byte(cfg.escape, 1'b0);
        add_byte(cfg.delim ^ cfg.mask, 1'b0); add_byte(cfg.delim, 1'b1);
        // bad opening byte
        add_byte(8'h41, 1'b0); add_byte(8'h42, 1'b0); add_byte(cfg.delim, 1'b1);
        // short frame
        add_byte(cfg.delim, 1'b0); add_byte(cfg.delim, 1'b1);
        // bad closing byte
        add_byte(cfg.delim, 1'b0); add_byte(8'h11, 1'b0); add_byte(8'h22, 1'b1);
        // interior delimiter
        add_byte(cfg.delim, 1'b0); add_byte(cfg.delim, 1'b0); add_byte(8'h33, 1'b0);
        add_byte(cfg.delim, 1'b1);
        // escape right before the closing byte
        add_byte(cfg.delim, 1'b0); add_byte(8'h55, 1'b0); add_byte(cfg.escape, 1'b0);
        add_byte(cfg.delim, 1'b1);
        // raw delimiter after an escape is data and decodes wrongly
        add_byte(cfg.delim, 1'b0); add_byte(cfg.escape, 1'b0); add_byte(cfg.delim, 1'b0);
        add_byte(cfg.delim, 1'b1);
        add_random_frames(20);

        // extreme codes, payload limit of one, sender idling
        configure(8'h00, 8'hFF, 8'hFF, 9'd1, 9'd256, 82, 0);
        add_random_frames(15);

        // opposite extremes, capacity of one, receiver stalling
        configure(8'hFF, 8'h00, 8'h00, 9'd256, 9'd1, 0, 82);
        add_random_frames(15);

        // capacity below limit, with a long receiver hold-off
        configure(8'h7E, 8'h7D, 8'h20, 9'd5, 9'd3, 8, 8);
        add_random_frames(20);
        @(negedge i_clk);
        hold_kick = 1'b1;
        @(negedge i_clk);
        hold_kick = 1'b0;

        // delimiter and escape equal, limit below capacity
        d = 8'($urandom_range(255));
        configure(d, d, 8'($urandom_range(255)), 9'd3, 9'd5, 8, 8);
        add_random_frames(15);

        // random codes and sizes, no idling
        d = 8'($urandom_range(255));
        configure(d, d ^ 8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                  9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), 0, 0);
        add_random_frames(15);

        // full-size payload and one byte over the limit
        d = 8'($urandom_range(255));
        configure(d, d ^ 8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                  9'd256, 9'd256, 0, 0);
        build_frame(256);
        send_frame();
        build_frame(257);
        send_frame();
        add_random_frames(10);

        wait_idle();
        $display("covered %0d bytes in, %0d data bytes out, frames ok/invalid/capacity %0d/%0d/%0d",
                 bytes_accepted, data_out, frames_ok, frames_invalid, frames_cap);
        $display("seven register settings incl. extremes, idle/stall phases and a long hold-off");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
